>>> rtl/assert_macros.svh
// assertion helpers for the running statistics filter checker
// both expect i_clk and i_rst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSF_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RSF_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/rsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared widths, codes and controller types of the running statistics filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 16;
    localparam int SPREAD_W   = 64;
    localparam int DEV_W      = 32;
    localparam int CAP_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CAP         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_PRIOR_MEAN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_PRIOR_SPREAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_PRIOR_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_PRIOR_MEAN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_PRIOR_SPREAD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_PRIOR_COUNT  = 3'd6;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT,
        S_ZCHK,
        S_MDIV,
        S_MEAN,
        S_MUL,
        S_ADD,
        S_DEV,
        S_VDIV,
        S_SQRT,
        S_NEXT,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_CLEAR,
        OP_LOAD,
        OP_CNT,
        OP_ZERO_INIT,
        OP_MDIV_GO,
        OP_MEAN,
        OP_MUL,
        OP_ADD,
        OP_DEV_ZERO,
        OP_VDIV_GO,
        OP_SQRT_GO,
        OP_DEV_STORE,
        OP_OUT
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic sel;   // 0 raw statistic, 1 filtered statistic
        logic acc;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic cnt_zero;
        logic cnt_lt2;
        logic dev_le;
    } t_dp_stat;

endpackage

>>> rtl/rsf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_in_if
// Command channel: mode and sample with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

>>> rtl/rsf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_out_if
// Result channel: both statistics after a step, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_avg;
    logic [31:0] raw_deviation;
    logic [63:0] raw_sum_sq;
    logic [15:0] raw_total;
    logic [31:0] filt_avg;
    logic [31:0] filt_deviation;
    logic [63:0] filt_sum_sq;
    logic [15:0] filt_total;
    logic        accepted;

    modport source (output valid, output raw_avg, output raw_deviation, output raw_sum_sq,
                    output raw_total, output filt_avg, output filt_deviation,
                    output filt_sum_sq, output filt_total, output accepted, input ready);
    modport sink   (input valid, input raw_avg, input raw_deviation, input raw_sum_sq,
                    input raw_total, input filt_avg, input filt_deviation,
                    input filt_sum_sq, input filt_total, input accepted, output ready);
endinterface

>>> rtl/rsf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_div
// Radix-2 restoring divider, 64-bit dividend by nonzero 16-bit divisor.
// ----------------------------------------------------------------------------
module rsf_div
    import rsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SPREAD_W-1:0] i_dividend,
    input  logic [COUNT_W-1:0]  i_divisor,
    output logic                o_busy,
    output logic [SPREAD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SPREAD_W + 1);

    logic [STEP_W-1:0]   r_cnt;
    logic [COUNT_W-1:0]  r_rem;
    logic [COUNT_W-1:0]  r_dvs;
    logic [SPREAD_W-1:0] r_quo;
    logic [COUNT_W:0]    trial;
    logic                ge;
    logic [COUNT_W:0]    diff;

    // one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quo[SPREAD_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEP_W'(SPREAD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            r_quo <= {r_quo[SPREAD_W-2:0], ge};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

>>> rtl/rsf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_sqrt
// Bitwise integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rsf_sqrt
    import rsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SPREAD_W-1:0] i_value,
    output logic                o_busy,
    output logic [DEV_W-1:0]    o_root
);

    logic [SPREAD_W-1:0] r_v;
    logic [SPREAD_W-1:0] r_res;
    logic [SPREAD_W-1:0] r_bit;
    logic [SPREAD_W-1:0] sum;
    logic                fits;

    always_comb begin
        sum  = r_res + r_bit;
        fits = r_v >= sum;
    end

    // trial bit walks down two places per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= {2'b01, {(SPREAD_W-2){1'b0}}};
        end else if (r_bit != '0) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (fits) begin
                r_v   <= r_v - sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_busy = (r_bit != '0);
    assign o_root = r_res[DEV_W-1:0];

endmodule

>>> rtl/rsf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_datapath
// Statistic registers, configuration registers, update arithmetic, shared
// divider and square root, and the result register.
// ----------------------------------------------------------------------------
module rsf_datapath
    import rsf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [SAMPLE_W-1:0]   o_raw_avg,
    output logic [DEV_W-1:0]      o_raw_deviation,
    output logic [SPREAD_W-1:0]   o_raw_sum_sq,
    output logic [COUNT_W-1:0]    o_raw_total,
    output logic [SAMPLE_W-1:0]   o_filt_avg,
    output logic [DEV_W-1:0]      o_filt_deviation,
    output logic [SPREAD_W-1:0]   o_filt_sum_sq,
    output logic [COUNT_W-1:0]    o_filt_total,
    output logic                  o_accepted
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration
    logic [CAP_W-1:0]    r_cap;
    logic [SAMPLE_W-1:0] r_raw_pm, r_filt_pm;
    logic [SPREAD_W-1:0] r_raw_ps, r_filt_ps;
    logic [COUNT_W-1:0]  r_raw_pc, r_filt_pc;

    // statistics, index 0 raw, 1 filtered
    logic [SAMPLE_W-1:0] r_mean   [2];
    logic [SPREAD_W-1:0] r_spread [2];
    logic [COUNT_W-1:0]  r_count  [2];
    logic [DEV_W-1:0]    r_dev    [2];

    // working registers
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_dmag;
    logic                r_dneg;
    logic [SPREAD_W-1:0] r_prod;
    logic                r_le;

    logic [SAMPLE_W-1:0] cur_mean;
    logic [SPREAD_W-1:0] cur_spread;
    logic [COUNT_W-1:0]  cur_count;
    logic [COUNT_W-1:0]  limit;
    logic [SAMPLE_W:0]   d;
    logic [SAMPLE_W-1:0] dmag;
    logic [SAMPLE_W-1:0] q;
    logic [SAMPLE_W:0]   step;
    logic [SAMPLE_W:0]   new_mean;
    logic [SAMPLE_W-1:0] d2mag;
    logic [SPREAD_W:0]   spread_sum;
    logic                div_start;
    logic [SPREAD_W-1:0] div_dividend;
    logic [COUNT_W-1:0]  div_divisor;
    logic                div_busy;
    logic [SPREAD_W-1:0] div_quo;
    logic                sqrt_busy;
    logic [DEV_W-1:0]    sqrt_root;

    // update arithmetic on the selected statistic
    always_comb begin
        cur_mean   = r_mean[i_cmd.sel];
        cur_spread = r_spread[i_cmd.sel];
        cur_count  = r_count[i_cmd.sel];
        if (!r_cap[CAP_W-1] && (r_cap[COUNT_W-1:0] != COUNT_MAX)) begin
            limit = r_cap[COUNT_W-1:0];
        end else begin
            limit = COUNT_MAX;
        end
        d          = {r_sample[SAMPLE_W-1], r_sample} - {cur_mean[SAMPLE_W-1], cur_mean};
        dmag       = d[SAMPLE_W] ? SAMPLE_W'(-d) : d[SAMPLE_W-1:0];
        q          = div_quo[SAMPLE_W-1:0];
        step       = r_dneg ? -{1'b0, q} : {1'b0, q};
        new_mean   = {cur_mean[SAMPLE_W-1], cur_mean} + step;
        // mean already updated when this is used
        d2mag      = d[SAMPLE_W] ? SAMPLE_W'(-d) : d[SAMPLE_W-1:0];
        spread_sum = {1'b0, cur_spread} + {1'b0, r_prod};
    end

    // divider operand select
    always_comb begin
        div_start    = 1'b0;
        div_dividend = cur_spread;
        div_divisor  = cur_count - 1'b1;
        if (i_cmd.op == OP_MDIV_GO) begin
            div_start    = 1'b1;
            div_dividend = SPREAD_W'(dmag);
            div_divisor  = cur_count;
        end else if (i_cmd.op == OP_VDIV_GO) begin
            div_start    = 1'b1;
        end
    end

    rsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    rsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT_GO),
        .i_value (div_quo),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= '1;
            r_raw_pm  <= '0;
            r_raw_ps  <= '0;
            r_raw_pc  <= '0;
            r_filt_pm <= '0;
            r_filt_ps <= '0;
            r_filt_pc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COUNT_CAP:         r_cap     <= i_cfg_data[CAP_W-1:0];
                CFG_RAW_PRIOR_MEAN:    r_raw_pm  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_RAW_PRIOR_SPREAD:  r_raw_ps  <= i_cfg_data[SPREAD_W-1:0];
                CFG_RAW_PRIOR_COUNT:   r_raw_pc  <= i_cfg_data[COUNT_W-1:0];
                CFG_FILT_PRIOR_MEAN:   r_filt_pm <= i_cfg_data[SAMPLE_W-1:0];
                CFG_FILT_PRIOR_SPREAD: r_filt_ps <= i_cfg_data[SPREAD_W-1:0];
                CFG_FILT_PRIOR_COUNT:  r_filt_pc <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // statistic state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_mean[k]   <= '0;
                r_spread[k] <= '0;
                r_count[k]  <= '0;
                r_dev[k]    <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_CLEAR: begin
                    for (int k = 0; k < 2; k++) begin
                        r_mean[k]   <= '0;
                        r_spread[k] <= '0;
                        r_count[k]  <= '0;
                        r_dev[k]    <= '0;
                    end
                end
                OP_LOAD: begin
                    r_mean[0]   <= r_raw_pm;
                    r_spread[0] <= r_raw_ps;
                    r_count[0]  <= r_raw_pc;
                    r_mean[1]   <= r_filt_pm;
                    r_spread[1] <= r_filt_ps;
                    r_count[1]  <= r_filt_pc;
                end
                OP_CNT: begin
                    if (cur_count < limit) r_count[i_cmd.sel] <= cur_count + 1'b1;
                end
                OP_ZERO_INIT: begin
                    r_mean[i_cmd.sel]   <= r_sample;
                    r_spread[i_cmd.sel] <= '0;
                end
                OP_MEAN:      r_mean[i_cmd.sel] <= new_mean[SAMPLE_W-1:0];
                OP_ADD: begin
                    r_spread[i_cmd.sel] <= spread_sum[SPREAD_W] ? '1
                                                                : spread_sum[SPREAD_W-1:0];
                end
                OP_DEV_ZERO:  r_dev[i_cmd.sel] <= '0;
                OP_DEV_STORE: r_dev[i_cmd.sel] <= sqrt_root;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LATCH) r_sample <= i_sample;
        if (i_cmd.op == OP_MDIV_GO) begin
            r_dmag <= dmag;
            r_dneg <= d[SAMPLE_W];
        end
        if (i_cmd.op == OP_MUL) r_prod <= r_dmag * d2mag;
        if (i_cmd.op == OP_DEV_ZERO) r_le <= 1'b1;
        if (i_cmd.op == OP_DEV_STORE) r_le <= (sqrt_root <= r_dev[i_cmd.sel]);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            o_raw_avg        <= r_mean[0];
            o_raw_deviation  <= r_dev[0];
            o_raw_sum_sq     <= r_spread[0];
            o_raw_total      <= r_count[0];
            o_filt_avg       <= r_mean[1];
            o_filt_deviation <= r_dev[1];
            o_filt_sum_sq    <= r_spread[1];
            o_filt_total     <= r_count[1];
            o_accepted       <= i_cmd.acc;
        end
    end

    assign o_stat.div_done  = !div_busy;
    assign o_stat.sqrt_done = !sqrt_busy;
    assign o_stat.cnt_zero  = (cur_count == '0);
    assign o_stat.cnt_lt2   = (cur_count < COUNT_W'(2));
    assign o_stat.dev_le    = r_le;

endmodule

>>> rtl/rsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_ctrl
// Sequencer: steps the datapath through one command and owns the handshakes.
// ----------------------------------------------------------------------------
module rsf_ctrl
    import rsf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_mode,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_sel, n_sel;
    logic   r_acc, n_acc;
    logic   r_out_valid, n_out_valid;
    t_op    op;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_NOP;
            r_sel       <= 1'b0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_sel       <= n_sel;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_sel       = r_sel;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        op          = OP_NOP;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode = t_mode'(i_mode);
                    n_sel  = 1'b0;
                    n_acc  = 1'b0;
                    unique case (t_mode'(i_mode))
                        MODE_PUSH: begin
                            op      = OP_LATCH;
                            n_state = S_CNT;
                        end
                        MODE_CLEAR: begin
                            op      = OP_CLEAR;
                            n_state = S_OUT;
                        end
                        MODE_LOAD: begin
                            op      = OP_LOAD;
                            n_state = S_DEV;
                        end
                        MODE_NOP: n_state = S_OUT;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_CNT: begin
                op      = OP_CNT;
                n_state = S_ZCHK;
            end
            S_ZCHK: begin
                if (i_stat.cnt_zero) begin
                    op      = OP_ZERO_INIT;
                    n_state = S_DEV;
                end else begin
                    op      = OP_MDIV_GO;
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                if (i_stat.div_done) n_state = S_MEAN;
            end
            S_MEAN: begin
                op      = OP_MEAN;
                n_state = S_MUL;
            end
            S_MUL: begin
                op      = OP_MUL;
                n_state = S_ADD;
            end
            S_ADD: begin
                op      = OP_ADD;
                n_state = S_DEV;
            end
            S_DEV: begin
                if (i_stat.cnt_lt2) begin
                    op      = OP_DEV_ZERO;
                    n_state = S_NEXT;
                end else begin
                    op      = OP_VDIV_GO;
                    n_state = S_VDIV;
                end
            end
            S_VDIV: begin
                if (i_stat.div_done) begin
                    op      = OP_SQRT_GO;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    op      = OP_DEV_STORE;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                // raw statistic done: filtered one follows for load, or for a
                // push that did not widen the raw deviation
                n_state = S_OUT;
                if (!r_sel) begin
                    if (r_mode == MODE_PUSH && i_stat.dev_le) begin
                        n_acc   = 1'b1;
                        n_sel   = 1'b1;
                        n_state = S_CNT;
                    end else if (r_mode == MODE_LOAD) begin
                        n_sel   = 1'b1;
                        n_state = S_DEV;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    op          = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.op    = op;
    assign o_cmd.sel   = r_sel;
    assign o_cmd.acc   = r_acc;
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/running_stat_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_stat_filter
// Raw and filtered Welford running mean / variance with count cap.
// ----------------------------------------------------------------------------
// One command is worked at a time. A push updates the raw statistic and then
// the filtered one when the raw deviation did not widen. Each uses the shared
// radix-2 divider for the mean step and the variance and the bitwise square
// root; the variance and square root are skipped while a count is below two.
// Prior load computes the deviation of both statistics; clear and no-op go
// straight to the result stage. A result that is not taken stalls the next
// command only at its own result stage. The result register holds the last
// result until taken while the next command is already accepted.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while no command is open; the block does not enforce it.
module running_stat_filter
    import rsf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rsf_in_if.sink                i_sample_ch,
    rsf_out_if.source             o_result_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample_ch.valid),
        .i_mode      (i_sample_ch.mode),
        .o_in_ready  (i_sample_ch.ready),
        .o_out_valid (o_result_ch.valid),
        .i_out_ready (o_result_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rsf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample         (i_sample_ch.sample),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_raw_avg        (o_result_ch.raw_avg),
        .o_raw_deviation  (o_result_ch.raw_deviation),
        .o_raw_sum_sq     (o_result_ch.raw_sum_sq),
        .o_raw_total      (o_result_ch.raw_total),
        .o_filt_avg       (o_result_ch.filt_avg),
        .o_filt_deviation (o_result_ch.filt_deviation),
        .o_filt_sum_sq    (o_result_ch.filt_sum_sq),
        .o_filt_total     (o_result_ch.filt_total),
        .o_accepted       (o_result_ch.accepted)
    );

endmodule

>>> rtl/rsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_checker
// Port-level checks of the running statistics filter, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_raw_dev,
    input logic [15:0] i_raw_total,
    input logic [31:0] i_filt_dev,
    input logic [15:0] i_filt_total
);

    // result held until its transfer
    `RSF_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")

    // one command in work at a time
    `RSF_ASSERT_NXT(a_one_cmd, i_in_valid && i_in_ready, !i_in_ready, "second command taken")

    // deviation is zero below two samples
    `RSF_ASSERT_IMP(a_raw_dev, i_out_valid && i_raw_total < 16'd2, i_raw_dev == 32'd0,
        "raw deviation nonzero")
    `RSF_ASSERT_IMP(a_filt_dev, i_out_valid && i_filt_total < 16'd2, i_filt_dev == 32'd0,
        "filtered deviation nonzero")

endmodule

bind running_stat_filter rsf_checker u_rsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample_ch.valid),
    .i_in_ready   (i_sample_ch.ready),
    .i_out_valid  (o_result_ch.valid),
    .i_out_ready  (o_result_ch.ready),
    .i_raw_dev    (o_result_ch.raw_deviation),
    .i_raw_total  (o_result_ch.raw_total),
    .i_filt_dev   (o_result_ch.filt_deviation),
    .i_filt_total (o_result_ch.filt_total)
);
